FILE: src/btc_pkg.sv
// Shared types, constants and helpers for the block tag cache.
// Used by btc_cell and block_tag_cache_fifo_evict; no dependencies.
package btc_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int HELD_W      = $clog2(MAX_ENTRIES + 1);
	localparam int TAG_W       = 32;
	localparam int CNT_W       = 16;
	localparam int LIMIT_W     = 32;
	localparam int SPB_W       = 8;
	localparam int BPS_W       = 13;
	localparam int BB_W        = SPB_W + BPS_W;
	localparam int CFG_IDX_W   = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPB   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BPS   = 2'd2;

	// Configuration reset values
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 32'd65536;
	localparam logic [SPB_W-1:0]   SPB_RST   = 8'd1;
	localparam logic [BPS_W-1:0]   BPS_RST   = 13'd512;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DECIDE,
		ST_INSERT,
		ST_DONE
	} btc_state_t;

	// Command broadcast from the controller to every cell
	typedef struct packed {
		logic [TAG_W-1:0]  blk;
		logic [HELD_W-1:0] oldest_age;
		logic              look;
		logic              hit_inc;
		logic              evict;
		logic              insert;
	} btc_cmd_t;

	// Status reported by one cell
	typedef struct packed {
		logic             valid;
		logic             match;
		logic             oldest;
		logic [TAG_W-1:0] tag;
		logic [CNT_W-1:0] cnt;
	} btc_stat_t;

	// Encode a one-hot entry vector into its slot number
	function automatic logic [SLOT_W-1:0] encode(input logic [MAX_ENTRIES-1:0] oh);
		logic [SLOT_W-1:0] enc;
		enc = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (oh[i]) begin
				enc = enc | SLOT_W'(i);
			end
		end
		return enc;
	endfunction

	// Saturating increment of an access count
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

FILE: src/btc_cell.sv
// One entry of the tag store: tag, valid mark, access count and insertion age.
// Depends on btc_pkg for the command and status structs.
module btc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  btc_pkg::btc_cmd_t cmd,
	input  logic              ins_sel,
	output btc_pkg::btc_stat_t stat
);

	logic                       valid_q;
	logic                       match_q;
	logic                       oldest_q;
	logic [btc_pkg::TAG_W-1:0]  tag_q;
	logic [btc_pkg::CNT_W-1:0]  cnt_q;
	logic [btc_pkg::SLOT_W-1:0] age_q;

	// Control state: valid mark and lookup flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			match_q  <= 1'b0;
			oldest_q <= 1'b0;
		end else begin
			if (cmd.look) begin
				match_q  <= valid_q && (tag_q == cmd.blk);
				oldest_q <= valid_q &&
					(btc_pkg::HELD_W'(age_q) == cmd.oldest_age);
			end
			if (cmd.evict && oldest_q) begin
				valid_q <= 1'b0;
			end
			if (cmd.insert && ins_sel) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Payload: tag, count and age
	always_ff @(posedge clk) begin
		if (cmd.hit_inc && match_q) begin
			cnt_q <= btc_pkg::sat_inc(cnt_q);
		end
		if (cmd.insert) begin
			if (ins_sel) begin
				tag_q <= cmd.blk;
				cnt_q <= '0;
				age_q <= '0;
			end else if (valid_q) begin
				age_q <= age_q + 1'b1;
			end
		end
	end

	assign stat.valid  = valid_q;
	assign stat.match  = match_q;
	assign stat.oldest = oldest_q;
	assign stat.tag    = tag_q;
	assign stat.cnt    = cnt_q;

endmodule

FILE: src/block_tag_cache_fifo_evict.sv
// Top level of the block tag cache: controller, configuration and the row of cells.
// Depends on btc_pkg and btc_cell.
//
// Fully associative tag store for disk block numbers with FIFO replacement.
// Requests arrive on the s_ group (block number in s_tdata); one result per
// request leaves on the m_ group. Configuration is written through cfg_we,
// cfg_index and cfg_data while no request is in flight; the user must keep to
// this, as the block itself does not enforce it.
//
// One request is processed at a time. After the request is accepted, the
// look state compares all tags in parallel and registers the block size
// product; the decide state makes the hit/evict decision (byte-limit
// compare); on a miss the insert state finds the lowest free slot and
// inserts; the done state then loads the result into the output register
// once it is free. A new request is taken only after that load.
//
// Reset clears all valid marks and the entry count at once and restores the
// configuration defaults. When the receiver stalls, the result holds in the
// output register and the block waits before finishing the next request.
module block_tag_cache_fifo_evict (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] block_number
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [5:0] slot, [21:6] access_count,
	                              // [53:22] evicted_block, [60:54] entry_count
	output logic [1:0]  m_tuser,  // [0] hit, [1] evicted
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int N = btc_pkg::MAX_ENTRIES;

	btc_pkg::btc_state_t state_q, state_d;
	btc_pkg::btc_cmd_t   cmd;
	btc_pkg::btc_stat_t  stat [N];

	logic [btc_pkg::LIMIT_W-1:0] limit_q;
	logic [btc_pkg::SPB_W-1:0]   spb_q;
	logic [btc_pkg::BPS_W-1:0]   bps_q;

	logic [btc_pkg::TAG_W-1:0]  blk_q;
	logic [btc_pkg::HELD_W-1:0] held_q;
	logic [btc_pkg::BB_W-1:0]   bb_q;
	logic                       hit_q;
	logic                       ev_q;
	logic [btc_pkg::SLOT_W-1:0] slot_q;
	logic [btc_pkg::CNT_W-1:0]  cnt_q;
	logic [btc_pkg::TAG_W-1:0]  ev_blk_q;

	logic                       out_valid_q;
	logic                       out_hit_q;
	logic                       out_ev_q;
	logic [5:0]                 out_slot_q;
	logic [btc_pkg::CNT_W-1:0]  out_cnt_q;
	logic [btc_pkg::TAG_W-1:0]  out_ev_blk_q;
	logic [6:0]                 out_count_q;

	logic [N-1:0]                   valid_v;
	logic [N-1:0]                   match_v;
	logic [N-1:0]                   oldest_v;
	logic [N-1:0]                   free_v;
	logic [N-1:0]                   lowest_v;
	logic [btc_pkg::TAG_W-1:0]      ev_blk_w;
	logic [btc_pkg::CNT_W-1:0]      hit_cnt_w;
	logic                           hit_w;
	logic                           ev_w;
	logic [btc_pkg::HELD_W:0]       held_inc;
	logic [btc_pkg::HELD_W+btc_pkg::BB_W:0] need_w;
	logic                           out_free;

	// Row of cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		btc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.ins_sel (lowest_v[i]),
			.stat    (stat[i])
		);
		assign valid_v[i]  = stat[i].valid;
		assign match_v[i]  = stat[i].match;
		assign oldest_v[i] = stat[i].oldest;
	end

	// Select tag and count of the flagged entries
	always_comb begin
		ev_blk_w  = '0;
		hit_cnt_w = '0;
		for (int i = 0; i < N; i++) begin
			if (oldest_v[i]) begin
				ev_blk_w = ev_blk_w | stat[i].tag;
			end
			if (match_v[i]) begin
				hit_cnt_w = hit_cnt_w | stat[i].cnt;
			end
		end
	end

	// Hit and eviction decision
	assign hit_w    = |match_v;
	assign held_inc = {1'b0, held_q} + 1'b1;
	assign need_w   = held_inc * bb_q;
	assign ev_w     = !hit_w && (held_q != '0) &&
		((need_w > limit_q) || (held_q >= btc_pkg::HELD_W'(N)));

	// Lowest free slot
	assign free_v   = ~valid_v;
	assign lowest_v = free_v & (~free_v + 1'b1);

	assign out_free = !out_valid_q || m_tready;

	// Next state and cell commands
	always_comb begin
		state_d        = state_q;
		cmd.blk        = blk_q;
		cmd.oldest_age = btc_pkg::HELD_W'(held_q - 1'b1);
		cmd.look       = 1'b0;
		cmd.hit_inc    = 1'b0;
		cmd.evict      = 1'b0;
		cmd.insert     = 1'b0;
		s_tready       = 1'b0;
		unique case (state_q)
			btc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = btc_pkg::ST_LOOK;
				end
			end
			btc_pkg::ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = btc_pkg::ST_DECIDE;
			end
			btc_pkg::ST_DECIDE: begin
				cmd.hit_inc = hit_w;
				cmd.evict   = ev_w;
				state_d     = hit_w ? btc_pkg::ST_DONE : btc_pkg::ST_INSERT;
			end
			btc_pkg::ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = btc_pkg::ST_DONE;
			end
			btc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = btc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = btc_pkg::ST_IDLE;
			end
		endcase
	end

	// State, entry count, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btc_pkg::ST_IDLE;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			limit_q     <= btc_pkg::LIMIT_RST;
			spb_q       <= btc_pkg::SPB_RST;
			bps_q       <= btc_pkg::BPS_RST;
		end else begin
			state_q <= state_d;
			if (state_q == btc_pkg::ST_DECIDE && ev_w) begin
				held_q <= held_q - 1'b1;
			end
			if (state_q == btc_pkg::ST_INSERT) begin
				held_q <= held_q + 1'b1;
			end
			if (state_q == btc_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					btc_pkg::CFG_LIMIT: limit_q <= cfg_data;
					btc_pkg::CFG_SPB:   spb_q   <= cfg_data[btc_pkg::SPB_W-1:0];
					btc_pkg::CFG_BPS:   bps_q   <= cfg_data[btc_pkg::BPS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Request payload and per-request results
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			blk_q <= s_tdata;
		end
		if (state_q == btc_pkg::ST_LOOK) begin
			bb_q <= spb_q * bps_q;
		end
		if (state_q == btc_pkg::ST_DECIDE) begin
			hit_q    <= hit_w;
			ev_q     <= ev_w;
			slot_q   <= btc_pkg::encode(match_v);
			cnt_q    <= btc_pkg::sat_inc(hit_cnt_w);
			ev_blk_q <= ev_w ? ev_blk_w : '0;
		end
		if (state_q == btc_pkg::ST_INSERT) begin
			slot_q <= btc_pkg::encode(lowest_v);
			cnt_q  <= '0;
		end
		if (state_q == btc_pkg::ST_DONE && out_free) begin
			out_hit_q    <= hit_q;
			out_ev_q     <= ev_q;
			out_slot_q   <= 6'(slot_q);
			out_cnt_q    <= cnt_q;
			out_ev_blk_q <= ev_blk_q;
			out_count_q  <= 7'(held_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_ev_q, out_hit_q};
	assign m_tdata  = {3'b000, out_count_q, out_ev_blk_q, out_cnt_q, out_slot_q};

endmodule

FILE: tb/btc_checker.sv
// Scoreboard for the block tag cache: predicts each lookup result and compares it.
// Watches the request, result and register-write ports of block_tag_cache_fifo_evict.
// Depends on btc_pkg for widths, register indexes and reset values.
`timescale 1ns / 100ps

module btc_checker import btc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [31:0]       s_tdata,  // [31:0] block_number
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [63:0]       m_tdata,  // [5:0] slot, [21:6] access_count,
	                                    // [53:22] evicted_block, [60:54] entry_count
	input  logic [1:0]        m_tuser,  // [0] hit, [1] evicted
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output int unsigned       outstanding,
	output int unsigned       fail_count,
	output int unsigned       hit_total,
	output int unsigned       evict_total
);

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  hits;
		logic              evicted;
		logic [TAG_W-1:0]  victim;
		logic [HELD_W-1:0] held;
	} lookup_res_t;

	// Shadow copy of the tag store and its registers
	logic [TAG_W-1:0]   tags [MAX_ENTRIES];
	logic               live [MAX_ENTRIES];
	logic [CNT_W-1:0]   hit_cnt [MAX_ENTRIES];
	int                 age [MAX_ENTRIES];
	int                 held;
	logic [LIMIT_W-1:0] byte_limit;
	logic [SPB_W-1:0]   blk_sectors;
	logic [BPS_W-1:0]   sector_bytes;

	lookup_res_t lookups_due [$];
	lookup_res_t want;
	lookup_res_t got;
	int unsigned errors;
	int unsigned results_seen;
	int unsigned hits_seen;
	int unsigned evicts_seen;

	// Look up one block, update the shadow store and return the expected result
	function automatic lookup_res_t cache_lookup(input logic [TAG_W-1:0] blk);
		lookup_res_t r;
		bit found;
		bit have_free;
		int s;
		logic [63:0] need;
		r = '0;
		found = 1'b0;
		s = 0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (!found && live[i] && tags[i] == blk) begin
				found = 1'b1;
				s = i;
			end
		end
		if (found) begin
			if (hit_cnt[s] != CNT_MAX)
				hit_cnt[s] = hit_cnt[s] + 1'b1;
		end else begin
			// Evict the oldest entry when the byte budget or the store runs out
			need = 64'(held + 1) * (64'(blk_sectors) * 64'(sector_bytes));
			if ((need > 64'(byte_limit) || held >= MAX_ENTRIES) && held > 0) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (!r.evicted && live[i] && age[i] == held - 1) begin
						r.evicted = 1'b1;
						r.victim = tags[i];
						live[i] = 1'b0;
					end
				end
				if (r.evicted)
					held--;
			end
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (live[i])
					age[i]++;
			end
			// Insert into the lowest free slot
			have_free = 1'b0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (!have_free && !live[i]) begin
					have_free = 1'b1;
					s = i;
				end
			end
			live[s] = 1'b1;
			tags[s] = blk;
			hit_cnt[s] = '0;
			age[s] = 0;
			held++;
		end
		r.hit = found;
		r.slot = SLOT_W'(s);
		r.hits = hit_cnt[s];
		r.held = HELD_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				live[i] = 1'b0;
				tags[i] = '0;
				hit_cnt[i] = '0;
				age[i] = 0;
			end
			held = 0;
			byte_limit = LIMIT_RST;
			blk_sectors = SPB_RST;
			sector_bytes = BPS_RST;
			lookups_due.delete();
			errors = 0;
			results_seen = 0;
			hits_seen = 0;
			evicts_seen = 0;
			outstanding <= 0;
			fail_count <= 0;
			hit_total <= 0;
			evict_total <= 0;
		end else begin
			// Track register writes; unmapped indexes are dropped
			if (cfg_we) begin
				case (cfg_index)
					CFG_LIMIT: byte_limit = cfg_data[LIMIT_W-1:0];
					CFG_SPB:   blk_sectors = cfg_data[SPB_W-1:0];
					CFG_BPS:   sector_bytes = cfg_data[BPS_W-1:0];
					default: ;
				endcase
			end

			// Predict on every accepted request
			if (s_tvalid && s_tready) begin
				want = cache_lookup(s_tdata[TAG_W-1:0]);
				lookups_due.push_back(want);
				if (want.hit)
					hits_seen++;
				if (want.evicted)
					evicts_seen++;
			end

			// Compare every accepted result with the oldest prediction
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.hit = m_tuser[0];
				got.evicted = m_tuser[1];
				got.slot = m_tdata[5:0];
				got.hits = m_tdata[21:6];
				got.victim = m_tdata[53:22];
				got.held = m_tdata[60:54];
				if (lookups_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("[%0t] result %0d arrived with no request pending: %h / %b",
							$realtime, results_seen, m_tdata, m_tuser);
				end else begin
					want = lookups_due.pop_front();
					if (got !== want || m_tdata[63:61] !== 3'b000) begin
						errors++;
						if (errors <= 10) begin
							$display("[%0t] result %0d mismatch", $realtime, results_seen);
							$display("  expected hit=%0d slot=%0d count=%0d evicted=%0d victim=%h held=%0d",
								want.hit, want.slot, want.hits, want.evicted, want.victim,
								want.held);
							$display("  actual   hit=%0d slot=%0d count=%0d evicted=%0d victim=%h held=%0d pad=%b",
								got.hit, got.slot, got.hits, got.evicted, got.victim, got.held,
								m_tdata[63:61]);
						end
					end
				end
			end

			outstanding <= lookups_due.size();
			fail_count <= errors;
			hit_total <= hits_seen;
			evict_total <= evicts_seen;
		end
	end

endmodule

FILE: tb/tb_top.sv
// Top of the block tag cache testbench: clock, reset, request and register stimulus.
// Instantiates block_tag_cache_fifo_evict and btc_checker; depends on btc_pkg.
`timescale 1ns / 100ps

module tb_top;
	import btc_pkg::*;

	// Index with no register behind it; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int unsigned outstanding;
	int unsigned fail_count;
	int unsigned hit_total;
	int unsigned evict_total;

	int unsigned cycles = 0;
	int unsigned requests_sent = 0;
	int unsigned settings_used = 0;
	int          rx_hold = 0;
	bit          rx_free = 1'b0;
	bit          tx_steady = 1'b0;

	block_tag_cache_fifo_evict uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	btc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count),
		.hit_total   (hit_total),
		.evict_total (evict_total)
	);

	always #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still due", cycles, outstanding);
			$display("Some tests failed");
			$finish;
		end
	end

	// Stall the result side at random, mostly briefly
	always @(posedge clk) begin
		if (rx_free) begin
			m_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if ($urandom_range(0, 99) < 20) begin
			m_tready <= 1'b0;
			rx_hold <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) :
				$urandom_range(7, 39);
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one request and hold it until accepted
	task automatic send_block(input logic [TAG_W-1:0] blk);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= blk;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests_sent++;
	endtask

	// Drop valid and wait until every request has its result
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Load all three registers; junk above a register's width must be ignored
	task automatic set_config(input logic [LIMIT_W-1:0] lim, input logic [SPB_W-1:0] spb,
			input logic [BPS_W-1:0] bps, input bit poke_spare);
		logic [31:0] junk;
		junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
		write_reg(CFG_LIMIT, lim);
		write_reg(CFG_SPB, {junk[31:SPB_W], spb});
		write_reg(CFG_BPS, {junk[31:BPS_W], bps});
		if (poke_spare)
			write_reg(CFG_SPARE, $urandom());
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Mix of a reused block pool, fresh blocks and the extreme numbers
	task automatic random_phase(input int n_items);
		logic [TAG_W-1:0] pool [128];
		logic [TAG_W-1:0] blk;
		int pool_n;
		int r;
		pool_n = $urandom_range(4, 120);
		for (int i = 0; i < pool_n; i++)
			pool[i] = $urandom();
		for (int k = 0; k < n_items; k++) begin
			if (k % 40 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_free = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 82)
				blk = pool[$urandom_range(0, pool_n - 1)];
			else if (r < 94)
				blk = $urandom();
			else if (r < 97)
				blk = '0;
			else
				blk = '1;
			send_block(blk);
			if ($urandom_range(0, 99) < 2)
				drain();
		end
		tx_steady = 1'b0;
		rx_free = 1'b0;
		drain();
	endtask

	initial begin
		logic [SPB_W-1:0] spb_r;
		logic [BPS_W-1:0] bps_r;
		logic [TAG_W-1:0] hot_blk;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero byte limit: first miss fills the empty store, later misses evict
		set_config(32'd0, SPB_RST, BPS_RST, 1'b1);
		send_block(32'h0000_0000);
		send_block(32'hFFFF_FFFF);
		send_block(32'hFFFF_FFFF);
		send_block(32'hFFFF_FFFF);
		send_block(32'h0000_0000);
		drain();

		// Zero sectors per block: size never forces an eviction
		set_config(32'hFFFF_FFFF, 8'd0, 13'h1FFF, 1'b0);
		send_block(32'hA5A5_A5A5);
		send_block(32'h5A5A_5A5A);
		send_block(32'h0000_0001);
		send_block(32'h8000_0000);
		send_block(32'h0000_0000);
		send_block(32'h5A5A_5A5A);
		drain();

		// Limit of exactly three largest blocks: the third fits, the fourth evicts
		set_config(32'd1572864, 8'd128, 13'd4096, 1'b0);
		send_block(32'd10);
		send_block(32'd20);
		send_block(32'd30);
		send_block(32'd40);
		send_block(32'd20);
		drain();

		// Reset values: only a full store evicts
		set_config(LIMIT_RST, SPB_RST, BPS_RST, 1'b0);
		random_phase(135);

		// Widest limit with the largest legal block
		set_config(32'hFFFF_FFFF, 8'd128, 13'd4096, 1'b0);
		random_phase(135);

		// Limit a whole number of blocks
		spb_r = 8'($urandom_range(1, 128));
		bps_r = 13'($urandom_range(1, 4096));
		set_config(32'(spb_r) * 32'(bps_r) * 32'($urandom_range(1, 40)), spb_r, bps_r, 1'b0);
		random_phase(135);

		// All register bits set, random limit of any magnitude
		set_config($urandom() >> $urandom_range(0, 31), 8'hFF, 13'h1FFF, 1'b0);
		random_phase(135);

		// Zero bytes per sector with a zero limit
		set_config(32'd0, 8'($urandom_range(1, 255)), 13'd0, 1'b0);
		random_phase(135);

		// Random byte budget up to 200000 bytes with random block size
		set_config($urandom_range(0, 200000), 8'($urandom_range(1, 16)),
			13'($urandom_range(1, 4096)), 1'b1);
		random_phase(135);

		// Hammer one block back to back so its access count keeps climbing
		set_config(LIMIT_RST, SPB_RST, BPS_RST, 1'b0);
		tx_steady = 1'b1;
		rx_free = 1'b1;
		hot_blk = $urandom();
		repeat (30)
			send_block(hot_blk);
		tx_steady = 1'b0;
		rx_free = 1'b0;
		drain();

		$display("Covered %0d requests under %0d register settings: %0d hits, %0d evictions",
			requests_sent, settings_used, hit_total, evict_total);
		if (fail_count == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
src/btc_pkg.sv
src/btc_cell.sv
src/block_tag_cache_fifo_evict.sv
tb/btc_checker.sv
tb/tb_top.sv
